### rtl/stps_pkg.sv
// Shared types and constants for the sum tree priority sampler.
// No dependencies; every other file imports this package.

package stps_pkg;

	// Fixed widths of the channel fields.
	localparam int LEAF_W  = 10;
	localparam int PRIO_W  = 32;
	localparam int VALUE_W = 42;

	// Operation codes carried in the cmd field of an input item.
	localparam logic CMD_SET    = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;        // clear one memory entry
		logic load_upd;   // capture an update item, read its leaf
		logic load_smp;   // capture a sample item, read the root's left child
		logic upd_leaf;   // write the leaf, take the delta, read the parent
		logic upd_anc;    // add the delta to one ancestor, read the next one
		logic smp_step;   // descend one level
		logic load_out;   // load the result register
	} stps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;   // clearing sweep is at its last entry
		logic at_top;     // parent of the current node is the root
		logic smp_last;   // the descent reaches the leaf level this cycle
	} stps_stat_t;

endpackage

### rtl/stps_in_if.sv
// Input channel of the sum tree priority sampler: valid/ready plus one item.
// Depends on stps_pkg for the field widths.

interface stps_in_if import stps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [LEAF_W-1:0]    leaf_index;
	logic [PRIO_W-1:0]    priority_req;
	logic [VALUE_W-1:0]   sample_value;

	modport source (output valid, output cmd, output leaf_index, output priority_req,
		output sample_value, input ready);
	modport sink (input valid, input cmd, input leaf_index, input priority_req,
		input sample_value, output ready);
endinterface

### rtl/stps_out_if.sv
// Result channel of the sum tree priority sampler: valid/ready plus one result.
// Depends on stps_pkg for the field widths.

interface stps_out_if import stps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [LEAF_W-1:0]    found_leaf;
	logic [PRIO_W-1:0]    leaf_weight;
	logic [VALUE_W-1:0]   total_weight;

	modport source (output valid, output found_leaf, output leaf_weight, output total_weight,
		input ready);
	modport sink (input valid, input found_leaf, input leaf_weight, input total_weight,
		output ready);
endinterface

### rtl/stps_dp.sv
// Datapath of the sum tree priority sampler: node memory, walk registers, result register.
// Depends on stps_pkg; driven by stps_ctrl through stps_cmd_t.

module stps_dp import stps_pkg::*; #(
	parameter int CAPACITY      = 1024,
	parameter int PRIORITY_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stps_cmd_t            cmd,
	output stps_stat_t           stat,
	input  logic [LEAF_W-1:0]    leaf_index,
	input  logic [PRIO_W-1:0]    priority_req,
	input  logic [VALUE_W-1:0]   sample_value,
	output logic [LEAF_W-1:0]    found_leaf,
	output logic [PRIO_W-1:0]    leaf_weight,
	output logic [VALUE_W-1:0]   total_weight
);

	localparam int LOG2    = $clog2(CAPACITY);
	localparam int ADDR_W  = LOG2 + 1;
	localparam int DEPTH   = 2 * CAPACITY;
	localparam int STORE_W = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
	localparam int SUM_W   = STORE_W + LOG2;
	localparam int CMP_W   = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;
	localparam int IDX_W   = (LOG2 > LEAF_W) ? LOG2 : LEAF_W;
	localparam int WGT_W   = (SUM_W > PRIO_W) ? SUM_W : PRIO_W;
	localparam logic [ADDR_W-1:0] ROOT      = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] ROOT_LEFT = ADDR_W'(2);

	// Heap order from 1: children of node n are 2n and 2n+1, leaf k is at CAPACITY+k.
	// The root sum lives in total_q, so memory entry 1 is never used.
	logic [SUM_W-1:0]  mem [DEPTH];
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic [SUM_W-1:0]  wr_data;
	logic [SUM_W-1:0]  rd_data_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [SUM_W-1:0]   total_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  node_q;
	logic [VALUE_W-1:0] val_q;
	logic [SUM_W-1:0]   cur_q;
	logic [SUM_W-1:0]   delta_q;
	logic [LEAF_W-1:0]  found_leaf_q;
	logic [PRIO_W-1:0]  leaf_weight_q;
	logic [VALUE_W-1:0] total_weight_q;

	logic [IDX_W-1:0]   idx_ext;
	logic [ADDR_W-1:0]  leaf_addr;
	logic [SUM_W-1:0]   prio_ext;
	logic [ADDR_W-1:0]  parent;
	logic [SUM_W-1:0]   delta;
	logic [CMP_W-1:0]   left_ext;
	logic [CMP_W-1:0]   val_ext;
	logic [CMP_W-1:0]   val_diff;
	logic               go_right;
	logic [ADDR_W-1:0]  next_node;
	logic [SUM_W-1:0]   cur_next;
	logic [IDX_W-1:0]   found_ext;
	logic [WGT_W-1:0]   weight_ext;
	logic [CMP_W-1:0]   total_ext;

	always_comb begin
		idx_ext   = IDX_W'(leaf_index);
		leaf_addr = {1'b1, idx_ext[LOG2-1:0]};
		prio_ext  = SUM_W'(priority_req[STORE_W-1:0]);
		parent    = {1'b0, addr_q[ADDR_W-1:1]};
		delta     = cur_q - rd_data_q;
		left_ext  = CMP_W'(rd_data_q);
		val_ext   = CMP_W'(val_q);
		go_right  = val_ext > left_ext;
		val_diff  = val_ext - left_ext;
		next_node = {node_q[ADDR_W-2:0], go_right};
		// On a right turn the right child's sum is the parent's sum less the left one.
		cur_next  = go_right ? (cur_q - rd_data_q) : rd_data_q;
		found_ext  = IDX_W'(node_q[LOG2-1:0]);
		weight_ext = WGT_W'(cur_q);
		total_ext  = CMP_W'(total_q);
	end

	always_comb begin
		if (cmd.load_upd) begin
			rd_addr = leaf_addr;
		end else if (cmd.load_smp) begin
			rd_addr = ROOT_LEFT;
		end else if (cmd.upd_leaf || cmd.upd_anc) begin
			rd_addr = parent;
		end else if (cmd.smp_step) begin
			rd_addr = {next_node[ADDR_W-2:0], 1'b0};
		end else begin
			rd_addr = addr_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.upd_leaf) begin
			wr_en   = 1'b1;
			wr_data = cur_q;
		end else if (cmd.upd_anc) begin
			wr_en   = 1'b1;
			wr_data = rd_data_q + delta_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.upd_leaf) begin
				total_q <= total_q + delta;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_upd) begin
			addr_q <= leaf_addr;
			node_q <= leaf_addr;
			cur_q  <= prio_ext;
		end
		if (cmd.load_smp) begin
			node_q <= ROOT;
			val_q  <= sample_value;
			cur_q  <= total_q;
		end
		if (cmd.upd_leaf) begin
			delta_q <= delta;
			addr_q  <= parent;
		end
		if (cmd.upd_anc) begin
			addr_q <= parent;
		end
		if (cmd.smp_step) begin
			node_q <= next_node;
			cur_q  <= cur_next;
			if (go_right) begin
				val_q <= val_diff[VALUE_W-1:0];
			end
		end
		if (cmd.load_out) begin
			found_leaf_q   <= found_ext[LEAF_W-1:0];
			leaf_weight_q  <= weight_ext[PRIO_W-1:0];
			total_weight_q <= total_ext[VALUE_W-1:0];
		end
	end

	always_comb begin
		stat.clr_last = &clr_q;
		stat.at_top   = (parent == ROOT);
		stat.smp_last = next_node[ADDR_W-1];
	end

	assign found_leaf   = found_leaf_q;
	assign leaf_weight  = leaf_weight_q;
	assign total_weight = total_weight_q;

endmodule

### rtl/stps_ctrl.sv
// Controller of the sum tree priority sampler: sequencer and result-valid flag.
// Depends on stps_pkg; drives stps_dp through stps_cmd_t.

module stps_ctrl import stps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  stps_stat_t stat,
	output stps_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR    = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_UPD_LEAF = 6'b000100,
		ST_UPD_ANC  = 6'b001000,
		ST_SAMPLE   = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == CMD_SAMPLE) begin
						cmd.load_smp = 1'b1;
						state_d      = ST_SAMPLE;
					end else begin
						cmd.load_upd = 1'b1;
						state_d      = ST_UPD_LEAF;
					end
				end
			end
			ST_UPD_LEAF: begin
				cmd.upd_leaf = 1'b1;
				state_d      = stat.at_top ? ST_DONE : ST_UPD_ANC;
			end
			ST_UPD_ANC: begin
				cmd.upd_anc = 1'b1;
				if (stat.at_top) begin
					state_d = ST_DONE;
				end
			end
			ST_SAMPLE: begin
				cmd.smp_step = 1'b1;
				if (stat.smp_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// The result register is free once its previous result is transferred.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/sum_tree_priority_sampler.sv
// Top level of the sum tree priority sampler: controller, datapath and channel hookup.
// Depends on stps_pkg, stps_in_if, stps_out_if, stps_ctrl and stps_dp.
//
//   channel  modport  moves
//   req      sink     cmd, leaf_index, priority_req, sample_value
//   rsp      source   found_leaf, leaf_weight, total_weight
//
// An update or a sample walks the tree level by level before the next transfer is
// possible; the node memory does one level per cycle with one read and one write port.
// After reset a clearing sweep writes all 2*CAPACITY memory entries, one per cycle,
// and req.ready stays low for those cycles.
// A finished result waits in the output register while the next item is accepted;
// only the following result waits for rsp to drain.

module sum_tree_priority_sampler import stps_pkg::*; #(
	parameter int CAPACITY      = 1024,
	parameter int PRIORITY_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	stps_in_if.sink   req,
	stps_out_if.source rsp
);

	stps_cmd_t  ctl_cmd;
	stps_stat_t dp_stat;
	logic       in_ready;
	logic       out_valid;

	stps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.cmd),
		.in_ready  (in_ready),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	stps_dp #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.stat         (dp_stat),
		.leaf_index   (req.leaf_index),
		.priority_req (req.priority_req),
		.sample_value (req.sample_value),
		.found_leaf   (rsp.found_leaf),
		.leaf_weight  (rsp.leaf_weight),
		.total_weight (rsp.total_weight)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	// The controller issues at most one datapath command per cycle.
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctl_cmd))
		else $error("more than one datapath command in a cycle");

	// No item is taken while the memory is being cleared.
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.clr |-> !req.ready)
		else $error("input ready during clearing sweep");

	// After a transfer in, the block is busy with that item in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input ready right after a transfer");

	// Loading the result register always presents a result.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.load_out |=> rsp.valid)
		else $error("result loaded but not presented");

endmodule

### test/sum_tree_priority_sampler_tb.sv
// Self-checking testbench for sum_tree_priority_sampler: directed and random set/sample traffic.
// Depends on stps_pkg, stps_in_if, stps_out_if and the sum_tree_priority_sampler RTL.

module sum_tree_priority_sampler_tb;
	import stps_pkg::*;

	localparam int CAPACITY      = 1024;
	localparam int PRIORITY_BITS = 32;
	localparam int LEAF_BASE     = CAPACITY - 1;
	localparam int NODE_COUNT    = 2 * CAPACITY - 1;
	localparam logic [63:0] PRIO_MASK = (64'd1 << PRIORITY_BITS) - 64'd1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam int CYCLE_LIMIT   = 400000;
	localparam int TAIL_CYCLES   = 40;

	typedef struct packed {
		logic [LEAF_W-1:0]  leaf;
		logic [PRIO_W-1:0]  weight;
		logic [VALUE_W-1:0] total;
	} tree_result_t;

	logic clk;
	logic arst_n;

	stps_in_if  req_ch ();
	stps_out_if rsp_ch ();

	sum_tree_priority_sampler #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the node sums, heap order, root at index 0.
	logic [63:0]  tree_sum [NODE_COUNT];
	tree_result_t expected_results [$];

	int error_count;
	int result_count;
	int set_count;
	int sample_count;
	int pause_count;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding",
			CYCLE_LIMIT, expected_results.size());
		$display("Verification failed");
		$finish;
	end

	// Applies one item to the shadow tree and returns the result it must produce.
	function automatic tree_result_t tree_apply(input logic c, input logic [LEAF_W-1:0] li,
			input logic [PRIO_W-1:0] p, input logic [VALUE_W-1:0] v);
		int unsigned  node;
		int unsigned  leaf_node;
		int unsigned  lc;
		logic [63:0]  rest;
		logic [63:0]  delta;
		logic [63:0]  prio64;
		tree_result_t r;
		if (c == CMD_SET) begin
			node = (int'(li) & (CAPACITY - 1)) + LEAF_BASE;
			leaf_node = node;
			prio64 = 64'(p) & PRIO_MASK;
			// Wrapping difference is exact because every true sum stays nonnegative.
			delta = prio64 - tree_sum[node];
			tree_sum[node] = prio64;
			while (node != 0) begin
				node = (node - 1) >> 1;
				tree_sum[node] = tree_sum[node] + delta;
			end
			// The result reports the leaf that was written, not the root.
			node = leaf_node;
		end else begin
			node = 0;
			rest = 64'(v);
			while (2 * node + 1 < NODE_COUNT) begin
				lc = 2 * node + 1;
				if (rest <= tree_sum[lc]) begin
					node = lc;
				end else begin
					rest = rest - tree_sum[lc];
					node = lc + 1;
				end
			end
		end
		r.leaf   = LEAF_W'(node - LEAF_BASE);
		r.weight = PRIO_W'(tree_sum[node]);
		r.total  = VALUE_W'(tree_sum[0]);
		return r;
	endfunction

	// Entered and left at a falling edge; the item is offered until its transfer.
	task automatic send_item(input logic c, input logic [LEAF_W-1:0] li,
			input logic [PRIO_W-1:0] p, input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= c;
		req_ch.leaf_index   <= li;
		req_ch.priority_req <= p;
		req_ch.sample_value <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_results.insert(expected_results.size(), tree_apply(c, li, p, v));
		if (c == CMD_SET) set_count++;
		else sample_count++;
		@(negedge clk);
	endtask

	// Holds the request side quiet until every outstanding result has arrived.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_empty_tree();
		send_item(CMD_SAMPLE, '0, '0, '0);
		send_item(CMD_SAMPLE, '1, '1, VALUE_MAX);
		send_item(CMD_SET, '1, '0, '0);
		send_item(CMD_SAMPLE, '0, '0, '0);
	endtask

	task automatic test_extreme_weights();
		send_item(CMD_SET, 10'd0, '1, '0);
		send_item(CMD_SET, 10'd1023, '1, VALUE_MAX);
		send_item(CMD_SET, 10'd512, 32'd1, '0);
		send_item(CMD_SAMPLE, '0, '0, '0);
		// Values equal to a cumulative boundary stay on the left side.
		send_item(CMD_SAMPLE, '0, '0, 42'h0_FFFF_FFFF);
		send_item(CMD_SAMPLE, '0, '0, 42'h1_0000_0000);
		send_item(CMD_SAMPLE, '0, '0, 42'h1_0000_0001);
		send_item(CMD_SAMPLE, '0, '0, 42'h1_FFFF_FFFF);
		send_item(CMD_SAMPLE, '0, '0, 42'h2_0000_0000);
		send_item(CMD_SAMPLE, '1, '1, VALUE_MAX);
	endtask

	task automatic test_weight_decrease();
		send_item(CMD_SET, 10'd0, '0, '0);
		send_item(CMD_SAMPLE, '0, '0, '0);
		send_item(CMD_SET, 10'd512, 32'h1234_5678, '0);
		send_item(CMD_SET, 10'h155, 32'hAAAA_5555, 42'h2AA_AAAA_AAAA);
		send_item(CMD_SET, 10'h2AA, 32'h5555_AAAA, 42'h155_5555_5555);
		send_item(CMD_SAMPLE, '0, '0, 42'd1);
		send_item(CMD_SAMPLE, 10'h2AA, 32'h5555_AAAA, 42'hAAAA_5555);
		send_item(CMD_SAMPLE, '0, '0, 42'hAAAA_5556);
	endtask

	// Mostly valid walks inside the current total, plus boundaries, overshoots and rewrites.
	task automatic test_random_traffic(input int n_items);
		logic               c;
		logic [LEAF_W-1:0]  li;
		logic [PRIO_W-1:0]  p;
		logic [VALUE_W-1:0] v;
		logic [63:0]        r64;
		logic [63:0]        prefix;
		int                 kind;
		int                 k;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(99);
			li = LEAF_W'($urandom);
			p  = $urandom;
			r64 = {$urandom, $urandom};
			v  = VALUE_W'(r64);
			if (kind < 45) begin
				c = CMD_SET;
				if ($urandom_range(3) == 0) li = LEAF_W'($urandom_range(7));
				case ($urandom_range(3))
					0: p = $urandom;
					1: p = PRIO_W'($urandom_range(255));
					2: p = $urandom_range(1) ? '1 : '0;
					default: p = $urandom >> $urandom_range(31);
				endcase
			end else if (kind < 85) begin
				c = CMD_SAMPLE;
				v = VALUE_W'(r64 % (tree_sum[0] + 64'd1));
			end else if (kind < 93) begin
				c = CMD_SAMPLE;
				k = $urandom_range(CAPACITY - 1);
				prefix = '0;
				for (int j = 0; j <= k; j++) prefix = prefix + tree_sum[LEAF_BASE + j];
				v = VALUE_W'(prefix + 64'($urandom_range(1)));
			end else begin
				c = CMD_SAMPLE;
				if ($urandom_range(3) == 0) v = VALUE_MAX;
			end
			send_item(c, li, p, v);
			if (i % 200 == 199) begin
				drain_results();
				pause_count++;
			end
		end
	endtask

	always @(posedge clk) begin : check_result
		tree_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("Result transfer with nothing expected: leaf %0d weight %0h total %0h",
					rsp_ch.found_leaf, rsp_ch.leaf_weight, rsp_ch.total_weight);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				result_count++;
				if (rsp_ch.found_leaf !== want.leaf) begin
					$error("found_leaf: expected %0d, actual %0d", want.leaf, rsp_ch.found_leaf);
					error_count++;
				end
				if (rsp_ch.leaf_weight !== want.weight) begin
					$error("leaf_weight: expected %0h, actual %0h", want.weight,
						rsp_ch.leaf_weight);
					error_count++;
				end
				if (rsp_ch.total_weight !== want.total) begin
					$error("total_weight: expected %0h, actual %0h", want.total,
						rsp_ch.total_weight);
					error_count++;
				end
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		error_count   = 0;
		result_count  = 0;
		set_count     = 0;
		sample_count  = 0;
		pause_count   = 0;
		send_idle_pct = 28;
		recv_idle_pct = 67;
		arst_n = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = CMD_SET;
		req_ch.leaf_index   = '0;
		req_ch.priority_req = '0;
		req_ch.sample_value = '0;
		for (int i = 0; i < NODE_COUNT; i++) tree_sum[i] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_empty_tree();
		test_extreme_weights();
		test_weight_decrease();
		drain_results();
		pause_count++;
		test_random_traffic(600);

		send_idle_pct = 67;
		recv_idle_pct = 28;
		test_random_traffic(575);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(575);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end
		$display("Checked %0d results from %0d set and %0d sample transfers", result_count,
			set_count, sample_count);
		$display("under three idle mixes with %0d full drain pauses; %0d mismatches",
			pause_count, error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/stps_pkg.sv
rtl/stps_in_if.sv
rtl/stps_out_if.sv
rtl/stps_dp.sv
rtl/stps_ctrl.sv
rtl/sum_tree_priority_sampler.sv
test/sum_tree_priority_sampler_tb.sv
